// ===== sv/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants
// register indexes, reset values, datapath widths and pipeline latencies
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 64;
	localparam int COORD_W   = 32;
	localparam int SCR_W     = 13;
	localparam int SCR_OUT_W = 16;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

	// reset values
	localparam logic [CFG_W-1:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
	localparam logic [CFG_W-1:0] RST_ROW0_COLS23 = 64'h0;
	localparam logic [CFG_W-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW1_COLS23 = 64'h0;
	localparam logic [CFG_W-1:0] RST_ROW2_COLS01 = 64'h0;
	localparam logic [CFG_W-1:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;
	localparam logic [SCR_W-1:0] RST_WIDTH       = 13'd640;
	localparam logic [SCR_W-1:0] RST_HEIGHT      = 13'd480;

	// highlight limits in whole units on the sum of two y values
	localparam int EDGE_HL_LIMIT    = 10;
	localparam int EDGE_HL_LIMIT_BC = 12;

	// datapath widths
	localparam int PROD_W  = 2 * COORD_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int CROSS_W = PROD_W + 1;
	localparam int PART_W  = CROSS_W;
	localparam int DET_W   = 98;
	localparam int NUM_W   = 46;
	localparam int DEN_W   = COORD_W + 1;
	localparam int QUO_W   = SCR_OUT_W;
	localparam int CMP_W   = 49;

	// divider latency: input stage, one stage per quotient bit, output stage
	localparam int DIV_LAT = QUO_W + 2;
	// lead of the determinant sign (registered in stage 8) over the divider operands (registered in stage 5)
	localparam int DET_LEAD = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NUM_W-1:0]   num_t;
	typedef logic signed [QUO_W-1:0]   scr_t;

	typedef struct packed {
		logic [2:0] zero;
		logic [2:0] draw;
		logic [2:0] hl;
	} side_t;

endpackage

// ===== sv/triangle_transform_cull_project.sv =====
// ----------------------------------------------------------------------------
// triangle_transform_cull_project
// transform, back-face cull and perspective projection of one triangle
// ----------------------------------------------------------------------------
// A triangle transfer is taken on every clock edge with start high (busy never
// rises), so one triangle per cycle is sustained. Each triangle gives exactly
// one result, shown for a single cycle with done high; the receiver cannot
// stall and results leave in order. The result comes through the projection
// path: five stages of transform and projection set-up, then the divider (an
// input stage, one quotient bit per stage over 16 stages and an output stage),
// then the result register. The cull sign is ready after eight stages and
// waits beside the divider.
// Configuration writes take effect at once and are meant for an empty pipe.
module triangle_transform_cull_project #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  tcc_pkg::coord_t                     ax,
	input  tcc_pkg::coord_t                     ay,
	input  tcc_pkg::coord_t                     az,
	input  tcc_pkg::coord_t                     bx,
	input  tcc_pkg::coord_t                     by_coord,
	input  tcc_pkg::coord_t                     bz,
	input  tcc_pkg::coord_t                     cx,
	input  tcc_pkg::coord_t                     cy,
	input  tcc_pkg::coord_t                     cz,
	input  logic                                cfg_wr_en,
	input  logic [tcc_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [tcc_pkg::CFG_W-1:0]           cfg_wdata,
	output logic                                done,
	output logic                                visible,
	output logic                                proj_fault,
	output tcc_pkg::scr_t                       sx_a,
	output tcc_pkg::scr_t                       sy_a,
	output tcc_pkg::scr_t                       sx_b,
	output tcc_pkg::scr_t                       sy_b,
	output tcc_pkg::scr_t                       sx_c,
	output tcc_pkg::scr_t                       sy_c,
	output logic [2:0]                          edge_draw_mask,
	output logic [2:0]                          edge_highlight_mask
);

	localparam int CW   = tcc_pkg::COORD_W;
	localparam int PW   = tcc_pkg::PROD_W;
	localparam int AW   = tcc_pkg::ACC_W;
	localparam int DFW  = tcc_pkg::DIFF_W;
	localparam int XW   = tcc_pkg::CROSS_W;
	localparam int RW   = tcc_pkg::PART_W;
	localparam int TW   = tcc_pkg::DET_W;
	localparam int SW   = tcc_pkg::SCR_W;
	localparam int LAT  = tcc_pkg::DIV_LAT;
	localparam int NLAT = tcc_pkg::DIV_LAT - tcc_pkg::DET_LEAD;

	// the pipe never holds off a transfer
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	tcc_pkg::coord_t   mat_q [0:2][0:3];
	logic [SW-1:0]     width_q;
	logic [SW-1:0]     height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0][0] <= tcc_pkg::RST_ROW0_COLS01[31:0];
			mat_q[0][1] <= tcc_pkg::RST_ROW0_COLS01[63:32];
			mat_q[0][2] <= tcc_pkg::RST_ROW0_COLS23[31:0];
			mat_q[0][3] <= tcc_pkg::RST_ROW0_COLS23[63:32];
			mat_q[1][0] <= tcc_pkg::RST_ROW1_COLS01[31:0];
			mat_q[1][1] <= tcc_pkg::RST_ROW1_COLS01[63:32];
			mat_q[1][2] <= tcc_pkg::RST_ROW1_COLS23[31:0];
			mat_q[1][3] <= tcc_pkg::RST_ROW1_COLS23[63:32];
			mat_q[2][0] <= tcc_pkg::RST_ROW2_COLS01[31:0];
			mat_q[2][1] <= tcc_pkg::RST_ROW2_COLS01[63:32];
			mat_q[2][2] <= tcc_pkg::RST_ROW2_COLS23[31:0];
			mat_q[2][3] <= tcc_pkg::RST_ROW2_COLS23[63:32];
			width_q     <= tcc_pkg::RST_WIDTH;
			height_q    <= tcc_pkg::RST_HEIGHT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tcc_pkg::REG_ROW0_COLS01: begin
					mat_q[0][0] <= cfg_wdata[31:0];
					mat_q[0][1] <= cfg_wdata[63:32];
				end
				tcc_pkg::REG_ROW0_COLS23: begin
					mat_q[0][2] <= cfg_wdata[31:0];
					mat_q[0][3] <= cfg_wdata[63:32];
				end
				tcc_pkg::REG_ROW1_COLS01: begin
					mat_q[1][0] <= cfg_wdata[31:0];
					mat_q[1][1] <= cfg_wdata[63:32];
				end
				tcc_pkg::REG_ROW1_COLS23: begin
					mat_q[1][2] <= cfg_wdata[31:0];
					mat_q[1][3] <= cfg_wdata[63:32];
				end
				tcc_pkg::REG_ROW2_COLS01: begin
					mat_q[2][0] <= cfg_wdata[31:0];
					mat_q[2][1] <= cfg_wdata[63:32];
				end
				tcc_pkg::REG_ROW2_COLS23: begin
					mat_q[2][2] <= cfg_wdata[31:0];
					mat_q[2][3] <= cfg_wdata[63:32];
				end
				tcc_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_wdata[SW-1:0];
				tcc_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_wdata[SW-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------

	// floor shift of the transform sum, then clamp to 32 bits
	function automatic tcc_pkg::coord_t sat32(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] sh;
		sh = a >>> FRAC_BITS;
		if ((&sh[AW-1:CW-1]) || !(|sh[AW-1:CW-1]))
			sat32 = sh[CW-1:0];
		else if (sh[AW-1])
			sat32 = {1'b1, {(CW-1){1'b0}}};
		else
			sat32 = {1'b0, {(CW-1){1'b1}}};
	endfunction

	// {draw, highlight} of one edge from object-space end points
	function automatic logic [1:0] edge_bits(
		input tcc_pkg::coord_t xa, input tcc_pkg::coord_t ya, input tcc_pkg::coord_t za,
		input tcc_pkg::coord_t xb, input tcc_pkg::coord_t yb, input tcc_pkg::coord_t zb,
		input int              lim_units
	);
		logic signed [DFW-1:0] one;
		logic signed [DFW-1:0] lim;
		logic signed [DFW-1:0] dx;
		logic signed [DFW-1:0] dz;
		logic signed [DFW-1:0] ysum;
		logic                  skip;
		one  = DFW'(1) <<< FRAC_BITS;
		lim  = DFW'(lim_units) <<< FRAC_BITS;
		dx   = $signed({xa[CW-1], xa}) - $signed({xb[CW-1], xb});
		dz   = $signed({za[CW-1], za}) - $signed({zb[CW-1], zb});
		ysum = $signed({ya[CW-1], ya}) + $signed({yb[CW-1], yb});
		skip = (dx == one || dx == -one) && (dz == one || dz == -one);
		edge_bits = {!skip, !skip && (ysum <= lim)};
	endfunction

	// ------------------------------------------------------------------
	// stage 1: matrix products and edge masks
	// ------------------------------------------------------------------
	tcc_pkg::coord_t vin [0:2][0:2];

	assign vin[0][0] = ax;
	assign vin[0][1] = ay;
	assign vin[0][2] = az;
	assign vin[1][0] = bx;
	assign vin[1][1] = by_coord;
	assign vin[1][2] = bz;
	assign vin[2][0] = cx;
	assign vin[2][1] = cy;
	assign vin[2][2] = cz;

	logic [1:0] e_ab;
	logic [1:0] e_ac;
	logic [1:0] e_bc;

	assign e_ab = edge_bits(ax, ay, az, bx, by_coord, bz, tcc_pkg::EDGE_HL_LIMIT);
	assign e_ac = edge_bits(ax, ay, az, cx, cy, cz, tcc_pkg::EDGE_HL_LIMIT);
	assign e_bc = edge_bits(bx, by_coord, bz, cx, cy, cz, tcc_pkg::EDGE_HL_LIMIT_BC);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	logic signed [PW-1:0] prod_s1 [0:2][0:2][0:2];
	logic [2:0]           draw_s1, draw_s2, draw_s3, draw_s4;
	logic [2:0]           hl_s1, hl_s2, hl_s3, hl_s4;

	always_ff @(posedge clk) begin
		for (int v = 0; v < 3; v++)
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					prod_s1[v][r][c] <= vin[v][c] * mat_q[r][c];
		draw_s1 <= {e_bc[1], e_ac[1], e_ab[1]};
		hl_s1   <= {e_bc[0], e_ac[0], e_ab[0]};
	end

	// ------------------------------------------------------------------
	// stage 2: exact row sums with translation
	// ------------------------------------------------------------------
	logic signed [AW-1:0] acc_s2 [0:2][0:2];

	always_ff @(posedge clk) begin
		for (int v = 0; v < 3; v++)
			for (int r = 0; r < 3; r++)
				acc_s2[v][r] <= AW'(prod_s1[v][r][0]) + AW'(prod_s1[v][r][1])
					+ AW'(prod_s1[v][r][2]) + (AW'(mat_q[r][3]) <<< FRAC_BITS);
		draw_s2 <= draw_s1;
		hl_s2   <= hl_s1;
	end

	// ------------------------------------------------------------------
	// stage 3: scale back and clamp
	// ------------------------------------------------------------------
	tcc_pkg::coord_t t_s3 [0:2][0:2];

	always_ff @(posedge clk) begin
		for (int v = 0; v < 3; v++)
			for (int r = 0; r < 3; r++)
				t_s3[v][r] <= sat32(acc_s2[v][r]);
		draw_s3 <= draw_s2;
		hl_s3   <= hl_s2;
	end

	// ------------------------------------------------------------------
	// stage 4: cross products of vertices b and c, projection terms
	// ------------------------------------------------------------------
	logic signed [PW-1:0]  cr_s4 [0:5];
	tcc_pkg::coord_t       t0_s4 [0:2];
	logic signed [DFW-1:0] dx_s4 [0:2];
	logic signed [DFW-1:0] dy_s4 [0:2];
	tcc_pkg::coord_t       z_s4  [0:2];

	always_ff @(posedge clk) begin
		cr_s4[0] <= t_s3[1][1] * t_s3[2][2];
		cr_s4[1] <= t_s3[1][2] * t_s3[2][1];
		cr_s4[2] <= t_s3[1][2] * t_s3[2][0];
		cr_s4[3] <= t_s3[1][0] * t_s3[2][2];
		cr_s4[4] <= t_s3[1][0] * t_s3[2][1];
		cr_s4[5] <= t_s3[1][1] * t_s3[2][0];
		for (int v = 0; v < 3; v++) begin
			t0_s4[v] <= t_s3[0][v];
			z_s4[v]  <= t_s3[v][2];
			dx_s4[v] <= $signed({t_s3[v][2][CW-1], t_s3[v][2]})
				- $signed({t_s3[v][0][CW-1], t_s3[v][0]});
			dy_s4[v] <= $signed({t_s3[v][2][CW-1], t_s3[v][2]})
				+ $signed({t_s3[v][1][CW-1], t_s3[v][1]});
		end
		draw_s4 <= draw_s3;
		hl_s4   <= hl_s3;
	end

	// ------------------------------------------------------------------
	// stage 5: face normal, projection numerators
	// ------------------------------------------------------------------
	logic signed [XW-1:0] n_s5    [0:2];
	tcc_pkg::coord_t      t0_s5   [0:2];
	tcc_pkg::num_t        numx_s5 [0:2];
	tcc_pkg::num_t        numy_s5 [0:2];
	tcc_pkg::coord_t      z_s5    [0:2];
	tcc_pkg::side_t       side_s5;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			n_s5[k]    <= XW'(cr_s4[2*k]) - XW'(cr_s4[2*k+1]);
			t0_s5[k]   <= t0_s4[k];
			numx_s5[k] <= $signed({1'b0, width_q}) * dx_s4[k];
			numy_s5[k] <= $signed({1'b0, height_q}) * dy_s4[k];
			z_s5[k]    <= z_s4[k];
			side_s5.zero[k] <= (z_s4[k] == '0);
		end
		side_s5.draw <= draw_s4;
		side_s5.hl   <= hl_s4;
	end

	// ------------------------------------------------------------------
	// stages 6 to 8: triple product sign, normal split in two halves
	// ------------------------------------------------------------------
	logic signed [RW-1:0] plo_s6 [0:2];
	logic signed [RW-1:0] phi_s6 [0:2];
	logic signed [TW-1:0] pk_s7  [0:2];
	logic signed [TW-1:0] det_sum;
	logic                 neg_s8;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			plo_s6[k] <= t0_s5[k] * $signed({1'b0, n_s5[k][31:0]});
			phi_s6[k] <= t0_s5[k] * $signed(n_s5[k][XW-1:32]);
			pk_s7[k]  <= (TW'(phi_s6[k]) <<< 32) + TW'(plo_s6[k]);
		end
		neg_s8 <= det_sum[TW-1];
	end

	assign det_sum = pk_s7[0] + pk_s7[1] + pk_s7[2];

	// ------------------------------------------------------------------
	// projection dividers, one per screen coordinate
	// ------------------------------------------------------------------
	tcc_pkg::scr_t qx [0:2];
	tcc_pkg::scr_t qy [0:2];

	for (genvar v = 0; v < 3; v++) begin : g_proj
		tcc_div u_div_x (
			.clk      (clk),
			.num      (numx_s5[v]),
			.den_half (z_s5[v]),
			.quo      (qx[v])
		);
		tcc_div u_div_y (
			.clk      (clk),
			.num      (numy_s5[v]),
			.den_half (z_s5[v]),
			.quo      (qy[v])
		);
	end

	// side band and cull decision kept in step with the dividers
	tcc_pkg::side_t side_d [0:LAT-1];
	logic           neg_d  [0:NLAT-1];
	logic           vld_d  [0:LAT-1];

	always_ff @(posedge clk) begin
		side_d[0] <= side_s5;
		for (int i = 1; i < LAT; i++)
			side_d[i] <= side_d[i-1];
		neg_d[0] <= neg_s8;
		for (int i = 1; i < NLAT; i++)
			neg_d[i] <= neg_d[i-1];
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			for (int i = 0; i < LAT; i++)
				vld_d[i] <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_d[0] <= vld_s5;
			for (int i = 1; i < LAT; i++)
				vld_d[i] <= vld_d[i-1];
		end
	end

	// cull-side valid copies for the determinant stages; vld_s8 feeds the visibility term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// ------------------------------------------------------------------
	// result register: one-cycle strobe, culled triangles report zeros
	// ------------------------------------------------------------------
	tcc_pkg::side_t side_fin;
	logic           vis_fin;
	logic           done_q;
	logic           visible_q;
	logic           fault_q;
	tcc_pkg::scr_t  sx_q [0:2];
	tcc_pkg::scr_t  sy_q [0:2];
	logic [2:0]     draw_q;
	logic [2:0]     hl_q;

	assign side_fin = side_d[LAT-1];
	assign vis_fin  = neg_d[NLAT-1] && (vld_d[LAT-1] || !vld_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_d[LAT-1];
	end

	always_ff @(posedge clk) begin
		visible_q <= vis_fin;
		fault_q   <= vis_fin && (|side_fin.zero);
		draw_q    <= vis_fin ? side_fin.draw : '0;
		hl_q      <= vis_fin ? side_fin.hl : '0;
		for (int v = 0; v < 3; v++) begin
			sx_q[v] <= (vis_fin && !side_fin.zero[v]) ? qx[v] : '0;
			sy_q[v] <= (vis_fin && !side_fin.zero[v]) ? qy[v] : '0;
		end
	end

	assign done                = done_q;
	assign visible             = visible_q;
	assign proj_fault          = fault_q;
	assign sx_a                = sx_q[0];
	assign sy_a                = sy_q[0];
	assign sx_b                = sx_q[1];
	assign sy_b                = sy_q[1];
	assign sx_c                = sx_q[2];
	assign sy_c                = sy_q[2];
	assign edge_draw_mask      = draw_q;
	assign edge_highlight_mask = hl_q;

endmodule

// ===== sv/tcc_div.sv =====
// ----------------------------------------------------------------------------
// tcc_div: pipelined saturating divider
// quotient of num by 2*den_half, truncated toward zero, saturated to 16 bits
// ----------------------------------------------------------------------------
module tcc_div (
	input  logic                clk,
	input  tcc_pkg::num_t       num,
	input  tcc_pkg::coord_t     den_half,
	output tcc_pkg::scr_t       quo
);

	localparam int STEPS = tcc_pkg::QUO_W;
	localparam int NW    = tcc_pkg::NUM_W;
	localparam int DW    = tcc_pkg::DEN_W;
	localparam int CW    = tcc_pkg::CMP_W;
	localparam int HW    = tcc_pkg::COORD_W;

	logic [NW-1:0]    rem_s [0:STEPS];
	logic [DW-1:0]    den_s [0:STEPS];
	logic [STEPS-1:0] quo_s [0:STEPS];
	logic             neg_s [0:STEPS];
	logic             ovf_s [0:STEPS];

	logic [NW-1:0]    num_mag;
	logic [HW-1:0]    half_mag;
	logic [DW-1:0]    den_mag;
	logic [STEPS-1:0] q_fin;
	logic signed [STEPS:0] q_negated;

	always_comb begin
		num_mag  = num[NW-1] ? NW'(-num) : NW'(num);
		half_mag = den_half[HW-1] ? HW'(-den_half) : HW'(den_half);
		den_mag  = {half_mag, 1'b0};
	end

	// input stage: magnitudes, sign and overflow
	always_ff @(posedge clk) begin
		rem_s[0] <= num_mag;
		den_s[0] <= den_mag;
		quo_s[0] <= '0;
		neg_s[0] <= num[NW-1] ^ den_half[HW-1];
		ovf_s[0] <= CW'(num_mag) >= (CW'(den_mag) << STEPS);
	end

	// one restoring step per stage, msb first
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int B = STEPS - 1 - k;
		logic [CW-1:0] sub;
		logic          take;

		assign sub  = CW'(den_s[k]) << B;
		assign take = CW'(rem_s[k]) >= sub;

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? NW'(CW'(rem_s[k]) - sub) : rem_s[k];
			quo_s[k+1] <= quo_s[k] | (take ? (STEPS'(1) << B) : '0);
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	assign q_fin     = quo_s[STEPS];
	assign q_negated = -$signed({1'b0, q_fin});

	// output stage: apply sign and saturate
	always_ff @(posedge clk) begin
		if (neg_s[STEPS]) begin
			if (ovf_s[STEPS] || q_fin > (STEPS'(1) << (STEPS - 1)))
				quo <= {1'b1, {(STEPS-1){1'b0}}};
			else
				quo <= STEPS'(q_negated);
		end else begin
			if (ovf_s[STEPS] || q_fin[STEPS-1])
				quo <= {1'b0, {(STEPS-1){1'b1}}};
			else
				quo <= q_fin;
		end
	end

endmodule
